// File: rtl/core/jst_pkg.sv
// types, constants and lookup functions shared by the json tokenizer
package jst_pkg;

  localparam int unsigned PosW      = 31;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;

  typedef enum logic [22:0] {
    PH_ROOT        = 23'b1 << 0,
    PH_VALUE       = 23'b1 << 1,
    PH_ARR_FIRST   = 23'b1 << 2,
    PH_OBJ_FIRST   = 23'b1 << 3,
    PH_OBJ_KEY     = 23'b1 << 4,
    PH_KEY         = 23'b1 << 5,
    PH_KEY_ESC     = 23'b1 << 6,
    PH_COLON       = 23'b1 << 7,
    PH_STR         = 23'b1 << 8,
    PH_STR_ESC     = 23'b1 << 9,
    PH_TRUE        = 23'b1 << 10,
    PH_FALSE       = 23'b1 << 11,
    PH_NULL        = 23'b1 << 12,
    PH_NUM_SIGN    = 23'b1 << 13,
    PH_NUM_INT     = 23'b1 << 14,
    PH_NUM_DOT     = 23'b1 << 15,
    PH_NUM_FRAC    = 23'b1 << 16,
    PH_NUM_EXP     = 23'b1 << 17,
    PH_NUM_EXPSIGN = 23'b1 << 18,
    PH_NUM_EXPDIG  = 23'b1 << 19,
    PH_AFTER       = 23'b1 << 20,
    PH_DONE        = 23'b1 << 21,
    PH_ERROR       = 23'b1 << 22
  } phase_e;

  typedef enum logic [3:0] {
    TK_BEGIN_OBJ = 4'd0,
    TK_END_OBJ   = 4'd1,
    TK_BEGIN_ARR = 4'd2,
    TK_END_ARR   = 4'd3,
    TK_KEY       = 4'd4,
    TK_STRING    = 4'd5,
    TK_INT       = 4'd6,
    TK_FLOAT     = 4'd7,
    TK_TRUE      = 4'd8,
    TK_FALSE     = 4'd9,
    TK_NULL      = 4'd10,
    TK_END       = 4'd11
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SYNTAX     = 3'd1,
    ST_BAD_UTF8   = 3'd2,
    ST_TOO_DEEP   = 3'd3,
    ST_UNEXP_END  = 3'd4
  } status_e;

  localparam logic [0:0] OpByte = 1'b0;
  localparam logic [0:0] OpEnd  = 1'b1;

  localparam logic [3:0] UtfAccept = 4'd0;
  localparam logic [3:0] UtfReject = 4'd1;

  typedef struct packed {
    logic [3:0]      kind;
    logic [PosW-1:0] start;
    logic [PosW-1:0] length;
    logic [2:0]      status;
    logic            last;
  } tok_t;

  typedef struct packed {
    logic v0;
    logic v1;
    tok_t tok0;
    tok_t tok1;
  } res_t;

  localparam logic [3:0] UtfNext [9][12] = '{
    '{4'd0,4'd1,4'd2,4'd3,4'd5,4'd8,4'd7,4'd1,4'd1,4'd1,4'd4,4'd6},
    '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd0,4'd1,4'd0,4'd1,4'd1},
    '{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd2,4'd1,4'd1},
    '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1},
    '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1},
    '{4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1},
    '{4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1}
  };

  localparam logic [7:0] WordTrue  [4] = '{"t", "r", "u", "e"};
  localparam logic [7:0] WordFalse [5] = '{"f", "a", "l", "s", "e"};
  localparam logic [7:0] WordNull  [4] = '{"n", "u", "l", "l"};

  function automatic logic [3:0] byte_class(input logic [7:0] c);
    logic [3:0] r;
    if (c < 8'h80)       r = 4'd0;
    else if (c < 8'h90)  r = 4'd1;
    else if (c < 8'hA0)  r = 4'd9;
    else if (c < 8'hC0)  r = 4'd7;
    else if (c < 8'hC2)  r = 4'd8;
    else if (c < 8'hE0)  r = 4'd2;
    else if (c == 8'hE0) r = 4'd10;
    else if (c == 8'hED) r = 4'd4;
    else if (c < 8'hF0)  r = 4'd3;
    else if (c == 8'hF0) r = 4'd11;
    else if (c < 8'hF4)  r = 4'd6;
    else if (c == 8'hF4) r = 4'd5;
    else                 r = 4'd8;
    return r;
  endfunction

  function automatic logic utf_step_reject(input logic [3:0] s, input logic [7:0] c,
                                           output logic [3:0] nxt);
    logic [3:0] ss;
    ss  = (s < 4'd9) ? s : UtfReject;
    nxt = UtfNext[ss][byte_class(c)];
    return nxt == UtfReject;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

endpackage

// File: rtl/core/jst_if.sv
// stream channel interfaces for input bytes and output tokens
interface jst_in_if;
  logic       valid;
  logic       ready;
  logic [0:0] operation;
  logic [7:0] data_byte;
  modport source (output valid, operation, data_byte, input ready);
  modport sink   (input valid, operation, data_byte, output ready);
endinterface

interface jst_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [30:0] token_start;
  logic [30:0] token_length;
  logic [2:0]  status;
  logic        last_of_run;
  modport source (output valid, token_kind, token_start, token_length, status, last_of_run,
                  input ready);
  modport sink   (input valid, token_kind, token_start, token_length, status, last_of_run,
                  output ready);
endinterface

// File: rtl/core/jst_parser.sv
// parser state machine with nesting stack, one word per cycle while fire_i is high
module jst_parser #(
  parameter int unsigned MAX_DEPTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [0:0]       op_i,
  input  logic [7:0]       byte_i,
  output jst_pkg::res_t    res_o
);

  localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  jst_pkg::phase_e             phase_q, phase_d;
  logic [DW-1:0]               depth_q, depth_d;
  logic [jst_pkg::PosW-1:0]    pos_q, pos_d;
  logic [jst_pkg::PosW-1:0]    beg_q, beg_d;
  logic [3:0]                  utf_q, utf_d;
  logic [2:0]                  lit_q, lit_d;
  logic                        flt_q, flt_d;
  logic                        top_q;

  logic                        stack_mem [MAX_DEPTH];
  logic [AW-1:0]               rd_addr;

  logic                        push, push_obj, vs, aft, fin, fv, m_v, top_obj;
  logic [2:0]                  fcode;
  jst_pkg::tok_t               m_tok, num_tok;
  logic [3:0]                  utf_n;
  logic                        utf_rej;
  logic [7:0]                  lit_ch;
  logic [2:0]                  lit_n;
  logic [3:0]                  lit_kind;
  logic                        halted;

  assign top_obj = (depth_q != '0) && top_q;
  assign halted  = (phase_q == jst_pkg::PH_DONE) || (phase_q == jst_pkg::PH_ERROR);

  always_comb begin
    utf_rej = jst_pkg::utf_step_reject(utf_q, byte_i, utf_n);
  end

  always_comb begin
    lit_ch   = 8'h00;
    lit_n    = 3'd4;
    lit_kind = jst_pkg::TK_TRUE;
    case (phase_q)
      jst_pkg::PH_TRUE: begin
        lit_n    = 3'd4;
        lit_kind = jst_pkg::TK_TRUE;
        if (lit_q < 3'd4) lit_ch = jst_pkg::WordTrue[lit_q[1:0]];
      end
      jst_pkg::PH_FALSE: begin
        lit_n    = 3'd5;
        lit_kind = jst_pkg::TK_FALSE;
        if (lit_q < 3'd5) lit_ch = jst_pkg::WordFalse[lit_q];
      end
      jst_pkg::PH_NULL: begin
        lit_n    = 3'd4;
        lit_kind = jst_pkg::TK_NULL;
        if (lit_q < 3'd4) lit_ch = jst_pkg::WordNull[lit_q[1:0]];
      end
      default: ;
    endcase
  end

  always_comb begin
    num_tok.kind   = flt_q ? jst_pkg::TK_FLOAT : jst_pkg::TK_INT;
    num_tok.start  = beg_q;
    num_tok.length = pos_q - beg_q;
    num_tok.status = jst_pkg::ST_OK;
    num_tok.last   = 1'b0;
  end

  always_comb begin
    phase_d  = phase_q;
    depth_d  = depth_q;
    pos_d    = pos_q;
    beg_d    = beg_q;
    utf_d    = utf_q;
    lit_d    = lit_q;
    flt_d    = flt_q;
    push     = 1'b0;
    push_obj = 1'b0;
    vs       = 1'b0;
    aft      = 1'b0;
    fin      = 1'b0;
    fv       = 1'b0;
    fcode    = jst_pkg::ST_SYNTAX;
    m_v      = 1'b0;
    m_tok    = '0;
    if (fire_i && !halted) begin
      if (op_i == jst_pkg::OpEnd) begin
        if (phase_q == jst_pkg::PH_NUM_INT || phase_q == jst_pkg::PH_NUM_FRAC ||
            phase_q == jst_pkg::PH_NUM_EXPDIG) begin
          fin = 1'b1;
        end
        if (phase_q == jst_pkg::PH_ROOT ||
            ((phase_q == jst_pkg::PH_AFTER || fin) && depth_q == '0)) begin
          m_v        = 1'b1;
          m_tok.kind = jst_pkg::TK_END;
          m_tok.start = pos_q;
          phase_d    = jst_pkg::PH_DONE;
        end else begin
          fv    = 1'b1;
          fcode = jst_pkg::ST_UNEXP_END;
        end
      end else begin
        unique case (phase_q)
          jst_pkg::PH_ROOT, jst_pkg::PH_VALUE: begin
            if (!jst_pkg::is_ws(byte_i)) vs = 1'b1;
          end
          jst_pkg::PH_ARR_FIRST: begin
            if (byte_i == "]") begin
              aft = 1'b1;
            end else if (!jst_pkg::is_ws(byte_i)) begin
              vs = 1'b1;
            end
          end
          jst_pkg::PH_OBJ_FIRST, jst_pkg::PH_OBJ_KEY: begin
            if (phase_q == jst_pkg::PH_OBJ_FIRST && byte_i == "}") begin
              aft = 1'b1;
            end else if (byte_i == "\"") begin
              beg_d   = pos_q + 31'd1;
              utf_d   = jst_pkg::UtfAccept;
              phase_d = jst_pkg::PH_KEY;
            end else if (!jst_pkg::is_ws(byte_i)) begin
              fv = 1'b1;
            end
          end
          jst_pkg::PH_KEY, jst_pkg::PH_STR: begin
            if (byte_i == "\"" && utf_q == jst_pkg::UtfAccept) begin
              m_v          = 1'b1;
              m_tok.kind   = (phase_q == jst_pkg::PH_KEY) ? jst_pkg::TK_KEY
                                                          : jst_pkg::TK_STRING;
              m_tok.start  = beg_q;
              m_tok.length = pos_q - beg_q;
              phase_d      = (phase_q == jst_pkg::PH_KEY) ? jst_pkg::PH_COLON
                                                          : jst_pkg::PH_AFTER;
            end else if (byte_i == "\\") begin
              utf_d   = jst_pkg::UtfAccept;
              phase_d = (phase_q == jst_pkg::PH_KEY) ? jst_pkg::PH_KEY_ESC
                                                     : jst_pkg::PH_STR_ESC;
            end else if (byte_i < 8'h20 && utf_q == jst_pkg::UtfAccept) begin
              fv    = 1'b1;
              fcode = jst_pkg::ST_BAD_UTF8;
            end else begin
              utf_d = utf_n;
              if (utf_rej) begin
                fv    = 1'b1;
                fcode = jst_pkg::ST_BAD_UTF8;
              end
            end
          end
          jst_pkg::PH_KEY_ESC: phase_d = jst_pkg::PH_KEY;
          jst_pkg::PH_STR_ESC: phase_d = jst_pkg::PH_STR;
          jst_pkg::PH_COLON: begin
            if (byte_i == ":") phase_d = jst_pkg::PH_VALUE;
            else if (!jst_pkg::is_ws(byte_i)) fv = 1'b1;
          end
          jst_pkg::PH_TRUE, jst_pkg::PH_FALSE, jst_pkg::PH_NULL: begin
            if (lit_q >= lit_n || byte_i != lit_ch) begin
              fv = 1'b1;
            end else begin
              lit_d = lit_q + 3'd1;
              if (lit_q + 3'd1 == lit_n) begin
                m_v          = 1'b1;
                m_tok.kind   = lit_kind;
                m_tok.start  = beg_q;
                m_tok.length = {28'd0, lit_n};
                phase_d      = jst_pkg::PH_AFTER;
              end
            end
          end
          jst_pkg::PH_NUM_SIGN: begin
            if (jst_pkg::is_digit(byte_i)) phase_d = jst_pkg::PH_NUM_INT;
            else fv = 1'b1;
          end
          jst_pkg::PH_NUM_INT: begin
            if (byte_i == ".") begin
              flt_d   = 1'b1;
              phase_d = jst_pkg::PH_NUM_DOT;
            end else if (byte_i == "e" || byte_i == "E") begin
              flt_d   = 1'b1;
              phase_d = jst_pkg::PH_NUM_EXP;
            end else if (!jst_pkg::is_digit(byte_i)) begin
              fin = 1'b1;
              aft = 1'b1;
            end
          end
          jst_pkg::PH_NUM_DOT: begin
            if (jst_pkg::is_digit(byte_i)) phase_d = jst_pkg::PH_NUM_FRAC;
            else fv = 1'b1;
          end
          jst_pkg::PH_NUM_FRAC: begin
            if (byte_i == "e" || byte_i == "E") begin
              phase_d = jst_pkg::PH_NUM_EXP;
            end else if (!jst_pkg::is_digit(byte_i)) begin
              fin = 1'b1;
              aft = 1'b1;
            end
          end
          jst_pkg::PH_NUM_EXP: begin
            if (byte_i == "+" || byte_i == "-") phase_d = jst_pkg::PH_NUM_EXPSIGN;
            else if (jst_pkg::is_digit(byte_i)) phase_d = jst_pkg::PH_NUM_EXPDIG;
            else fv = 1'b1;
          end
          jst_pkg::PH_NUM_EXPSIGN: begin
            if (jst_pkg::is_digit(byte_i)) phase_d = jst_pkg::PH_NUM_EXPDIG;
            else fv = 1'b1;
          end
          jst_pkg::PH_NUM_EXPDIG: begin
            if (!jst_pkg::is_digit(byte_i)) begin
              fin = 1'b1;
              aft = 1'b1;
            end
          end
          jst_pkg::PH_AFTER: aft = 1'b1;
          default: ;
        endcase

        // start of a value
        if (vs) begin
          beg_d = pos_q;
          lit_d = 3'd1;
          flt_d = 1'b0;
          if (byte_i == "{" || byte_i == "[") begin
            if (depth_q >= DW'(MAX_DEPTH)) begin
              fv    = 1'b1;
              fcode = jst_pkg::ST_TOO_DEEP;
            end else begin
              push        = 1'b1;
              push_obj    = (byte_i == "{");
              depth_d     = depth_q + DW'(1);
              m_v         = 1'b1;
              m_tok.kind  = push_obj ? jst_pkg::TK_BEGIN_OBJ : jst_pkg::TK_BEGIN_ARR;
              m_tok.start = pos_q;
              phase_d     = push_obj ? jst_pkg::PH_OBJ_FIRST : jst_pkg::PH_ARR_FIRST;
            end
          end else if (byte_i == "\"") begin
            beg_d   = pos_q + 31'd1;
            utf_d   = jst_pkg::UtfAccept;
            phase_d = jst_pkg::PH_STR;
          end else if (byte_i == "t") begin
            phase_d = jst_pkg::PH_TRUE;
          end else if (byte_i == "f") begin
            phase_d = jst_pkg::PH_FALSE;
          end else if (byte_i == "n") begin
            phase_d = jst_pkg::PH_NULL;
          end else if (byte_i == "-") begin
            phase_d = jst_pkg::PH_NUM_SIGN;
          end else if (jst_pkg::is_digit(byte_i)) begin
            phase_d = jst_pkg::PH_NUM_INT;
          end else begin
            fv = 1'b1;
          end
        end

        // closing brackets, separators, and empty containers
        if (aft) begin
          phase_d = jst_pkg::PH_AFTER;
          if ((phase_q == jst_pkg::PH_ARR_FIRST && byte_i == "]") ||
              (phase_q == jst_pkg::PH_OBJ_FIRST && byte_i == "}")) begin
            m_v         = 1'b1;
            m_tok.kind  = (byte_i == "}") ? jst_pkg::TK_END_OBJ : jst_pkg::TK_END_ARR;
            m_tok.start = pos_q;
            if (depth_q != '0) depth_d = depth_q - DW'(1);
          end else if (jst_pkg::is_ws(byte_i)) begin
            phase_d = jst_pkg::PH_AFTER;
          end else if (depth_q == '0) begin
            fv = 1'b1;
          end else if (byte_i == ",") begin
            phase_d = top_obj ? jst_pkg::PH_OBJ_KEY : jst_pkg::PH_VALUE;
          end else if ((byte_i == "}" && top_obj) || (byte_i == "]" && !top_obj)) begin
            m_v         = 1'b1;
            m_tok.kind  = (byte_i == "}") ? jst_pkg::TK_END_OBJ : jst_pkg::TK_END_ARR;
            m_tok.start = pos_q;
            depth_d     = depth_q - DW'(1);
          end else begin
            fv = 1'b1;
          end
        end
      end

      if (fv) begin
        m_v          = 1'b1;
        m_tok.kind   = jst_pkg::TK_END;
        m_tok.start  = pos_q;
        m_tok.length = '0;
        m_tok.status = fcode;
        phase_d      = jst_pkg::PH_ERROR;
        push         = 1'b0;
        depth_d      = depth_q;
      end
      if (op_i == jst_pkg::OpByte && phase_d != jst_pkg::PH_ERROR) begin
        pos_d = pos_q + 31'd1;
      end
    end
  end

  always_comb begin
    res_o.v0        = fin | m_v;
    res_o.v1        = fin & m_v;
    res_o.tok0      = fin ? num_tok : m_tok;
    res_o.tok0.last = !(fin && m_v);
    res_o.tok1      = m_tok;
    res_o.tok1.last = 1'b1;
  end

  assign rd_addr = (depth_d == '0) ? '0 : AW'(depth_d - DW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= jst_pkg::PH_ROOT;
      depth_q <= '0;
      pos_q   <= '0;
      beg_q   <= '0;
      utf_q   <= jst_pkg::UtfAccept;
      lit_q   <= '0;
      flt_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      depth_q <= depth_d;
      pos_q   <= pos_d;
      beg_q   <= beg_d;
      utf_q   <= utf_d;
      lit_q   <= lit_d;
      flt_q   <= flt_d;
    end
  end

  // stack memory, top entry kept in a register
  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_mem[AW'(depth_q)] <= push_obj;
      top_q                   <= push_obj;
    end else if (fire_i) begin
      top_q <= stack_mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/jst_out_fifo.sv
// small token queue taking up to two words per cycle and giving one while pop_i is high
module jst_out_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  jst_pkg::res_t res_i,
  input  logic          pop_i,
  output logic          room_o,
  output logic          valid_o,
  output jst_pkg::tok_t tok_o
);

  jst_pkg::tok_t                 mem_q [jst_pkg::FifoDepth];
  logic [jst_pkg::FifoPtrW-1:0]  wp_q, rp_q;
  logic [jst_pkg::FifoPtrW:0]    cnt_q, cnt_after_pop, n_push;
  logic                          pop;

  assign pop           = pop_i && valid_o;
  assign valid_o       = cnt_q != '0;
  assign tok_o         = mem_q[rp_q];
  assign cnt_after_pop = cnt_q - {{jst_pkg::FifoPtrW{1'b0}}, pop};
  assign room_o        = cnt_after_pop <= (jst_pkg::FifoPtrW + 1)'(jst_pkg::FifoDepth - 2);
  assign n_push        = {{jst_pkg::FifoPtrW{1'b0}}, res_i.v0} +
                         {{jst_pkg::FifoPtrW{1'b0}}, res_i.v1};

  always_ff @(posedge clk_i) begin
    if (res_i.v0) mem_q[wp_q] <= res_i.tok0;
    if (res_i.v1) mem_q[wp_q + 2'd1] <= res_i.tok1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + n_push[jst_pkg::FifoPtrW-1:0];
      rp_q  <= rp_q + {{(jst_pkg::FifoPtrW-1){1'b0}}, pop};
      cnt_q <= cnt_after_pop + n_push;
    end
  end

endmodule

// File: rtl/core/json_stream_tokenizer_core.sv
// top level of the streaming json tokenizer
// in_i takes one word per item: operation 0 carries a document byte, operation 1
// marks the end of the document. out_o gives tokens with kind, start offset,
// length, status and last_of_run on the final token caused by an input word.
// one input word is taken per cycle while the output queue has room. a word sits
// in the input register while the parser works on it, and then the parser state
// and up to two tokens in a four-entry output queue are written, so the first
// token is offered from the queue once its word has passed the input register.
// the rate is bound by the parser step on the byte register and by the output
// port, which gives one token per cycle: a number followed by a bracket yields
// two tokens from one byte.
// the nesting stack is a memory of MAX_DEPTH one-bit entries with the top entry
// held in a register; it needs no clearing after reset.
// reset returns the parser to the start of a document with the position at zero.
// after the end token or an error, further words are taken and dropped until
// reset. when the receiver stalls, the queue fills and in_i.ready drops once
// fewer than two entries are free.
module json_stream_tokenizer_core #(
  parameter int unsigned MAX_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  jst_in_if.sink     in_i,
  jst_out_if.source  out_o
);

  logic          s_valid_q;
  logic [0:0]    s_op_q;
  logic [7:0]    s_byte_q;
  logic          fire, room;
  jst_pkg::res_t res;
  jst_pkg::tok_t tok;

  assign fire       = s_valid_q && room;
  assign in_i.ready = !s_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s_op_q   <= in_i.operation;
      s_byte_q <= in_i.data_byte;
    end
  end

  jst_parser #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .op_i   (s_op_q),
    .byte_i (s_byte_q),
    .res_o  (res)
  );

  jst_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res),
    .pop_i   (out_o.ready),
    .room_o  (room),
    .valid_o (out_o.valid),
    .tok_o   (tok)
  );

  assign out_o.token_kind   = tok.kind;
  assign out_o.token_start  = tok.start;
  assign out_o.token_length = tok.length;
  assign out_o.status       = tok.status;
  assign out_o.last_of_run  = tok.last;

endmodule
